[hw/rtl/bde_pkg.sv]
`timescale 1ns / 1ps

package bde_pkg;

  // Button bank size and field widths
  localparam int NUM_BUTTONS = 6;
  localparam int CODE_W      = 3;
  localparam int THRESH_W    = 16;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 1'b1;

  // Reset value of both thresholds
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd50;

  // Thresholds handed to every cell
  typedef struct packed {
    logic [THRESH_W-1:0] press;
    logic [THRESH_W-1:0] release_th;
  } bde_thresh_t;

endpackage

[hw/rtl/bde_in_if.sv]
`timescale 1ns / 1ps

interface bde_in_if;
  logic                            valid;
  logic                            ready;
  logic [bde_pkg::NUM_BUTTONS-1:0] raw_levels;
  logic                            detect_rising;

  modport source (output valid, output raw_levels, output detect_rising, input ready);
  modport sink   (input valid, input raw_levels, input detect_rising, output ready);
endinterface

[hw/rtl/bde_out_if.sv]
`timescale 1ns / 1ps

interface bde_out_if;
  logic                            valid;
  logic                            ready;
  logic [bde_pkg::CODE_W-1:0]      button_code;
  logic [bde_pkg::NUM_BUTTONS-1:0] edge_mask;
  logic [bde_pkg::NUM_BUTTONS-1:0] debounced_levels;

  modport source (output valid, output button_code, output edge_mask,
                  output debounced_levels, input ready);
  modport sink   (input valid, input button_code, input edge_mask,
                  input debounced_levels, output ready);
endinterface

[hw/rtl/button_debounce_edge_detect_unit.sv]
`timescale 1ns / 1ps

// Channel | Dir | Payload                                        | Handshake
// in_ch   | in  | raw_levels[5:0], detect_rising                 | valid/ready
// out_ch  | out | button_code[2:0], edge_mask[5:0], debounced_levels[5:0] | valid/ready
// cfg_*   | in  | cfg_index (0 press, 1 release), cfg_wdata[15:0] | cfg_we
//
// One item per cycle while the output is not stalled; its result is registered and shows in the cycle after acceptance.
// All buttons update in the same cycle, the code ripples along the row of cells.
// rst_n is synchronous; thresholds reset to 50, buttons to released.
// in_ch.ready stays high while the output register is empty or being taken.
module button_debounce_edge_detect_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bde_in_if.sink                        in_ch,
  bde_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bde_pkg::THRESH_W-1:0]  cfg_wdata
);

  localparam int NB = bde_pkg::NUM_BUTTONS;

  bde_pkg::bde_thresh_t thresh_r;
  logic                          tick;
  logic [bde_pkg::CODE_W-1:0]    code_chain [NB+1];
  logic [NB-1:0]                 edge_vec, deb_vec;
  logic                          out_valid_r;
  logic [bde_pkg::CODE_W-1:0]    code_r;
  logic [NB-1:0]                 edge_r, deb_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.press      <= bde_pkg::THRESH_RESET;
      thresh_r.release_th <= bde_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bde_pkg::REG_PRESS_THRESHOLD:   thresh_r.press      <= cfg_wdata;
        bde_pkg::REG_RELEASE_THRESHOLD: thresh_r.release_th <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: take an item whenever the output register frees up
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign tick        = in_ch.valid && in_ch.ready;

  // Row of button cells
  assign code_chain[0] = '0;
  for (genvar i = 0; i < NB; i++) begin : g_cell
    bde_cell #(
      .TIMER_BITS (TIMER_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .tick          (tick),
      .lvl           (in_ch.raw_levels[i]),
      .detect_rising (in_ch.detect_rising),
      .thresh        (thresh_r),
      .code_in       (code_chain[i]),
      .code_out      (code_chain[i+1]),
      .edge_hit      (edge_vec[i]),
      .deb_out       (deb_vec[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      code_r <= code_chain[NB];
      edge_r <= edge_vec;
      deb_r  <= deb_vec;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.button_code      = code_r;
  assign out_ch.edge_mask        = edge_r;
  assign out_ch.debounced_levels = deb_r;

endmodule

[hw/rtl/bde_cell.sv]
`timescale 1ns / 1ps

// One button: level tracker, saturating timer, debounced flag.
// Passes the highest-edge code on to the next cell.
module bde_cell #(
  parameter int TIMER_BITS = 16,
  parameter int CELL_IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick,
  input  logic                       lvl,
  input  logic                       detect_rising,
  input  bde_pkg::bde_thresh_t       thresh,
  input  logic [bde_pkg::CODE_W-1:0] code_in,
  output logic [bde_pkg::CODE_W-1:0] code_out,
  output logic                       edge_hit,
  output logic                       deb_out
);

  localparam int CMP_W = (TIMER_BITS > bde_pkg::THRESH_W) ? TIMER_BITS : bde_pkg::THRESH_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [bde_pkg::CODE_W-1:0] MY_CODE = bde_pkg::CODE_W'(CELL_IDX + 1);

  logic                  last_raw_r, last_raw_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  deb_r, deb_nxt;
  logic [CMP_W-1:0]      timer_ext, press_ext, rel_ext;

  // Timer: clear on change, else count up and saturate
  always_comb begin
    last_raw_nxt = lvl;
    if (lvl != last_raw_r) begin
      timer_nxt = '0;
    end else if (timer_r != TIMER_MAX) begin
      timer_nxt = timer_r + 1'b1;
    end else begin
      timer_nxt = timer_r;
    end
  end

  assign timer_ext = CMP_W'(timer_nxt);
  assign press_ext = CMP_W'(thresh.press);
  assign rel_ext   = CMP_W'(thresh.release_th);

  // Debounced flag follows a level held beyond its threshold
  always_comb begin
    deb_nxt = deb_r;
    if (!last_raw_nxt) begin
      if (timer_ext > press_ext) begin
        deb_nxt = 1'b1;
      end
    end else begin
      if (timer_ext > rel_ext) begin
        deb_nxt = 1'b0;
      end
    end
  end

  assign edge_hit = detect_rising ? (!deb_r && deb_nxt) : (deb_r && !deb_nxt);
  assign deb_out  = deb_nxt;
  assign code_out = edge_hit ? MY_CODE : code_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      timer_r    <= '0;
      deb_r      <= 1'b0;
    end else if (tick) begin
      last_raw_r <= last_raw_nxt;
      timer_r    <= timer_nxt;
      deb_r      <= deb_nxt;
    end
  end

endmodule

[hw/rtl/bde_checker.sv]
`timescale 1ns / 1ps

module bde_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bde_pkg::CODE_W-1:0]      button_code,
  input logic [bde_pkg::NUM_BUTTONS-1:0] edge_mask
);

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An empty output stage always takes items
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  // No code without an edge and no edge without a code
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((button_code == '0) == (edge_mask == '0)))
    else $error("button code and edge mask disagree");

  // Code names the highest set bit of the edge mask
  a_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (button_code != '0) |->
      edge_mask[button_code - 1'b1] && ((edge_mask >> button_code) == '0))
    else $error("button code is not the highest edge");

endmodule

bind button_debounce_edge_detect_unit bde_checker u_bde_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .button_code (out_ch.button_code),
  .edge_mask   (out_ch.edge_mask)
);
